>>> rtl/lvbm_pkg.sv
package lvbm_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_BITS  = 32;
    localparam int NORM_BITS  = 30;
    localparam int SPLIT_BITS = 24;
    localparam int SAT_BITS   = 64;

    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST  = 2'd3;

    typedef enum logic [1:0] {
        MAT_VIEW  = 2'd0,
        MAT_FULL  = 2'd1,
        MAT_YAXIS = 2'd2
    } t_mat;

endpackage

>>> rtl/lvbm_cross.sv
module lvbm_cross #(
    parameter int A_BITS    = 18,
    parameter int SIDE_BITS = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [2:0][A_BITS-1:0]     i_a,
    input  logic [2:0][A_BITS-1:0]     i_b,
    input  logic [SIDE_BITS-1:0]       i_side,
    output logic                       o_valid,
    output logic [2:0][2*A_BITS:0]     o_c,
    output logic [SIDE_BITS-1:0]       o_side
);

    localparam int PB = 2 * A_BITS;

    logic signed [PB-1:0]    r_p [6];
    logic [SIDE_BITS-1:0]    r_side0;
    logic [SIDE_BITS-1:0]    r_side1;
    logic [2:0][PB:0]        r_c;
    logic [1:0]              r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]  <= $signed(i_a[1]) * $signed(i_b[2]);
            r_p[1]  <= $signed(i_a[2]) * $signed(i_b[1]);
            r_p[2]  <= $signed(i_a[2]) * $signed(i_b[0]);
            r_p[3]  <= $signed(i_a[0]) * $signed(i_b[2]);
            r_p[4]  <= $signed(i_a[0]) * $signed(i_b[1]);
            r_p[5]  <= $signed(i_a[1]) * $signed(i_b[0]);
            r_side0 <= i_side;
            r_c[0]  <= (PB+1)'(r_p[0]) - (PB+1)'(r_p[1]);
            r_c[1]  <= (PB+1)'(r_p[2]) - (PB+1)'(r_p[3]);
            r_c[2]  <= (PB+1)'(r_p[4]) - (PB+1)'(r_p[5]);
            r_side1 <= r_side0;
        end
    end

    assign o_valid = r_vld[1];
    assign o_c     = r_c;
    assign o_side  = r_side1;

endmodule

>>> rtl/lvbm_norm.sv
module lvbm_norm #(
    parameter int IN_BITS   = 33,
    parameter int FRAC_BITS = 16,
    parameter int SIDE_BITS = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [2:0][IN_BITS-1:0]     i_vec,
    input  logic [SIDE_BITS-1:0]        i_side,
    output logic                        o_valid,
    output logic                        o_ok,
    output logic [2:0][FRAC_BITS+1:0]   o_vec,
    output logic [SIDE_BITS-1:0]        o_side
);

    localparam int UB  = lvbm_pkg::NORM_BITS;
    localparam int NS  = $clog2(IN_BITS);
    localparam int XW  = IN_BITS + UB - 1;
    localparam int SQB = 2 * UB + 2;
    localparam int RB  = UB + 1;
    localparam int QB  = FRAC_BITS + 1;
    localparam int DW  = UB + FRAC_BITS + 2;
    localparam int VB  = FRAC_BITS + 2;
    localparam int L   = NS + RB + QB + 5;

    typedef struct packed {
        logic [SIDE_BITS-1:0] side;
        logic [2:0]           neg;
        logic                 nz;
    } t_car;

    t_car                r_car [L];
    logic [L-1:0]        r_vld;

    logic [2:0][IN_BITS-1:0] w_mag;
    logic [IN_BITS-1:0]      w_max;

    logic [XW-1:0]       r_su [NS+1][3];
    logic [IN_BITS-1:0]  r_sm [NS+1];
    logic [2*UB-1:0]     r_sq [3];
    logic [UB-1:0]       r_uq [3];
    logic [SQB-1:0]      r_rem [RB+1];
    logic [RB-1:0]       r_root [RB+1];
    logic [UB-1:0]       r_ur [RB+1][3];
    logic [DW-1:0]       r_dr [QB+1][3];
    logic [QB-1:0]       r_dq [QB+1][3];
    logic [RB-1:0]       r_dl [QB+1];
    logic [2:0][VB-1:0]  r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = i_vec[i][IN_BITS-1] ? (~i_vec[i] + 1'b1) : i_vec[i];
        end
        w_max = w_mag[0];
        if (w_mag[1] > w_max) w_max = w_mag[1];
        if (w_mag[2] > w_max) w_max = w_mag[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_car[0].side <= i_side;
            r_car[0].nz   <= |w_max;
            for (int i = 0; i < 3; i++) begin
                r_car[0].neg[i] <= i_vec[i][IN_BITS-1];
            end
            for (int s = 1; s < L; s++) begin
                r_car[s] <= r_car[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sm[0] <= w_max;
            for (int i = 0; i < 3; i++) begin
                r_su[0][i] <= XW'(w_mag[i]) << (UB - 1);
            end
        end
    end

    for (genvar k = 1; k <= NS; k++) begin : g_srch
        localparam int SH = 1 << (NS - k);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ((r_sm[k-1] >> SH) != '0) begin
                    r_sm[k] <= r_sm[k-1] >> SH;
                    for (int i = 0; i < 3; i++) begin
                        r_su[k][i] <= r_su[k-1][i] >> SH;
                    end
                end else begin
                    r_sm[k] <= r_sm[k-1];
                    for (int i = 0; i < 3; i++) begin
                        r_su[k][i] <= r_su[k-1][i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_uq[i] <= r_su[NS][i][UB-1:0];
                r_sq[i] <= r_su[NS][i][UB-1:0] * r_su[NS][i][UB-1:0];
            end
            r_rem[0]  <= SQB'(r_sq[0]) + SQB'(r_sq[1]) + SQB'(r_sq[2]);
            r_root[0] <= '0;
            r_ur[0]   <= r_uq;
        end
    end

    for (genvar j = 1; j <= RB; j++) begin : g_sqrt
        localparam int B = RB - j;
        logic [SQB:0] w_dlt;
        assign w_dlt = ((SQB+1)'(r_root[j-1]) << (B + 1)) + ((SQB+1)'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ((SQB+1)'(r_rem[j-1]) >= w_dlt) begin
                    r_rem[j]  <= r_rem[j-1] - SQB'(w_dlt);
                    r_root[j] <= r_root[j-1] | (RB'(1) << B);
                end else begin
                    r_rem[j]  <= r_rem[j-1];
                    r_root[j] <= r_root[j-1];
                end
                r_ur[j] <= r_ur[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dl[0] <= r_root[RB];
            for (int i = 0; i < 3; i++) begin
                r_dr[0][i] <= (DW'(r_ur[RB][i]) << FRAC_BITS) + DW'(r_root[RB] >> 1);
                r_dq[0][i] <= '0;
            end
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_div
        localparam int B = QB - j;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dl[j] <= r_dl[j-1];
                for (int i = 0; i < 3; i++) begin
                    if (r_dr[j-1][i] >= (DW'(r_dl[j-1]) << B)) begin
                        r_dr[j][i] <= r_dr[j-1][i] - (DW'(r_dl[j-1]) << B);
                        r_dq[j][i] <= r_dq[j-1][i] | (QB'(1) << B);
                    end else begin
                        r_dr[j][i] <= r_dr[j-1][i];
                        r_dq[j][i] <= r_dq[j-1][i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (!r_car[L-2].nz) begin
                    r_out[i] <= '0;
                end else if (r_car[L-2].neg[i]) begin
                    r_out[i] <= -VB'(r_dq[QB][i]);
                end else begin
                    r_out[i] <= VB'(r_dq[QB][i]);
                end
            end
        end
    end

    assign o_valid = r_vld[L-1];
    assign o_ok    = r_car[L-1].nz;
    assign o_vec   = r_out;
    assign o_side  = r_car[L-1].side;

endmodule

>>> rtl/lookat_view_billboard_matrix.sv
// Channel   Direction  Handshake          Payload
// request   in         i_valid / o_stall  i_eye_*, i_target_*, i_up_*
// row       out        o_valid / i_stall  o_matrix_id, o_row_index, o_col0..3,
//                                         o_degenerate, o_last_row
// One request gives twelve rows; the row serializer takes no new request until the last of them is taken.
// With the default widths a request passes through the input stage, three normalize pipelines
// of 59 stages in series, three cross stages of 2, two dot stages and the row register before
// its first row is valid.
// Synchronous active-low reset clears the valid bits and the row counters.
// The whole pipeline holds while the row register is busy, row-side stalls included.
module lookat_view_billboard_matrix #(
    parameter int FRAC_BITS = lvbm_pkg::FRAC_BITS,
    parameter int WORD_BITS = lvbm_pkg::WORD_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [WORD_BITS-1:0] i_eye_x,
    input  logic signed [WORD_BITS-1:0] i_eye_y,
    input  logic signed [WORD_BITS-1:0] i_eye_z,
    input  logic signed [WORD_BITS-1:0] i_target_x,
    input  logic signed [WORD_BITS-1:0] i_target_y,
    input  logic signed [WORD_BITS-1:0] i_target_z,
    input  logic signed [WORD_BITS-1:0] i_up_x,
    input  logic signed [WORD_BITS-1:0] i_up_y,
    input  logic signed [WORD_BITS-1:0] i_up_z,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_matrix_id,
    output logic [1:0]                  o_row_index,
    output logic signed [WORD_BITS-1:0] o_col0,
    output logic signed [WORD_BITS-1:0] o_col1,
    output logic signed [WORD_BITS-1:0] o_col2,
    output logic signed [WORD_BITS-1:0] o_col3,
    output logic                        o_degenerate,
    output logic                        o_last_row
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int VB  = F + 2;
    localparam int CB  = 2 * VB + 1;
    localparam int YB  = F + 3;
    localparam int SP  = lvbm_pkg::SPLIT_BITS;
    localparam int HB  = W - SP + 1;
    localparam int MB  = VB - 1;
    localparam int RW  = W + 2;
    localparam int DSW = W + 4;
    localparam int SB  = lvbm_pkg::SAT_BITS;

    localparam logic signed [SB-1:0] WMAX  = (SB'(1) <<< (W - 1)) - SB'(1);
    localparam logic signed [SB-1:0] WMIN  = -WMAX - SB'(1);
    localparam logic signed [SB-1:0] ONE_Q = SB'(1) <<< F;

    typedef struct packed {
        logic [2:0][W-1:0]  eye;
        logic [2:0][VB-1:0] zx;
        logic [2:0][VB-1:0] un;
        logic               ok;
    } t_s1;

    typedef struct packed {
        logic [2:0][W-1:0]  eye;
        logic [2:0][VB-1:0] zx;
        logic [2:0][VB-1:0] un;
        logic [2:0][VB-1:0] xx;
        logic               ok;
    } t_s2;

    typedef struct packed {
        logic [2:0][W-1:0]  eye;
        logic [2:0][VB-1:0] zx;
        logic [2:0][VB-1:0] un;
        logic [2:0][VB-1:0] xx;
        logic [2:0][VB-1:0] yx;
        logic               ok;
    } t_s3;

    function automatic logic [W-1:0] f_sat(input logic signed [SB-1:0] v);
        logic [W-1:0] res;
        if (v > WMAX) begin
            res = WMAX[W-1:0];
        end else if (v < WMIN) begin
            res = WMIN[W-1:0];
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    logic w_en;

    logic              r_s0_vld;
    logic [2:0][W-1:0] r_eye;
    logic [2:0][W:0]   r_dir;
    logic [2:0][W:0]   r_up;

    logic               z_vld, z_ok, u_ok;
    logic [2:0][VB-1:0] z_vec, u_vec;
    logic [3*W-1:0]     z_side;
    t_s1                w_s1_in, c1_side, x_side;
    logic               c1_vld, x_vld, x_ok;
    logic [2:0][CB-1:0] c1_c, c2_c, c3_c;
    logic [2:0][VB-1:0] x_vec, y_vec;
    t_s2                w_s2_in, c2_side, y_side;
    logic               c2_vld, y_vld, y_ok;
    t_s3                w_s3_in, c3_side;
    logic               c3_vld;

    logic               r_d1_vld;
    t_s3                r_d1_s;
    logic [2:0][YB-1:0] r_d1_yz;
    logic [HB+MB-1:0]   r_d1_a [3][3];
    logic [SP+MB-1:0]   r_d1_b [3][3];
    logic               r_d1_n [3][3];

    logic               r_d2_vld;
    t_s3                r_d2_s;
    logic [2:0][YB-1:0] r_d2_yz;
    logic [RW-1:0]      r_d2_r [3][3];

    logic               r_it_vld;
    lvbm_pkg::t_mat     r_mat, n_mat;
    logic [1:0]         r_row, n_row;
    logic               r_it_ok;
    logic [2:0][W-1:0]  r_xx, r_yx, r_zx, r_un, r_yz, r_dot;
    logic [W-1:0]       w_one;
    logic [2:0][W-1:0]  w_vec;
    logic [3:0][W-1:0]  w_col;
    logic               w_take, w_last;

    assign w_take  = r_it_vld && !i_stall;
    assign w_last  = (r_mat == lvbm_pkg::MAT_YAXIS) && (r_row == lvbm_pkg::ROW_LAST);
    assign w_en    = !r_it_vld || (w_take && w_last);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_eye[0] <= i_eye_x;
            r_eye[1] <= i_eye_y;
            r_eye[2] <= i_eye_z;
            r_dir[0] <= (W+1)'(i_target_x) - (W+1)'(i_eye_x);
            r_dir[1] <= (W+1)'(i_target_y) - (W+1)'(i_eye_y);
            r_dir[2] <= (W+1)'(i_target_z) - (W+1)'(i_eye_z);
            r_up[0]  <= (W+1)'(i_up_x);
            r_up[1]  <= (W+1)'(i_up_y);
            r_up[2]  <= (W+1)'(i_up_z);
        end
    end

    lvbm_norm #(.IN_BITS(W + 1), .FRAC_BITS(F), .SIDE_BITS(3 * W)) u_norm_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_s0_vld),
        .i_vec(r_dir), .i_side(r_eye),
        .o_valid(z_vld), .o_ok(z_ok), .o_vec(z_vec), .o_side(z_side)
    );

    lvbm_norm #(.IN_BITS(W + 1), .FRAC_BITS(F), .SIDE_BITS(1)) u_norm_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_s0_vld),
        .i_vec(r_up), .i_side(1'b0),
        .o_valid(), .o_ok(u_ok), .o_vec(u_vec), .o_side()
    );

    assign w_s1_in.eye = z_side;
    assign w_s1_in.zx  = z_vec;
    assign w_s1_in.un  = u_vec;
    assign w_s1_in.ok  = z_ok && u_ok;

    lvbm_cross #(.A_BITS(VB), .SIDE_BITS($bits(t_s1))) u_cross_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(z_vld),
        .i_a(u_vec), .i_b(z_vec), .i_side(w_s1_in),
        .o_valid(c1_vld), .o_c(c1_c), .o_side(c1_side)
    );

    lvbm_norm #(.IN_BITS(CB), .FRAC_BITS(F), .SIDE_BITS($bits(t_s1))) u_norm_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(c1_vld),
        .i_vec(c1_c), .i_side(c1_side),
        .o_valid(x_vld), .o_ok(x_ok), .o_vec(x_vec), .o_side(x_side)
    );

    assign w_s2_in.eye = x_side.eye;
    assign w_s2_in.zx  = x_side.zx;
    assign w_s2_in.un  = x_side.un;
    assign w_s2_in.xx  = x_vec;
    assign w_s2_in.ok  = x_side.ok && x_ok;

    lvbm_cross #(.A_BITS(VB), .SIDE_BITS($bits(t_s2))) u_cross_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(x_vld),
        .i_a(x_side.zx), .i_b(x_vec), .i_side(w_s2_in),
        .o_valid(c2_vld), .o_c(c2_c), .o_side(c2_side)
    );

    lvbm_norm #(.IN_BITS(CB), .FRAC_BITS(F), .SIDE_BITS($bits(t_s2))) u_norm_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(c2_vld),
        .i_vec(c2_c), .i_side(c2_side),
        .o_valid(y_vld), .o_ok(y_ok), .o_vec(y_vec), .o_side(y_side)
    );

    assign w_s3_in.eye = y_side.eye;
    assign w_s3_in.zx  = y_side.zx;
    assign w_s3_in.un  = y_side.un;
    assign w_s3_in.xx  = y_side.xx;
    assign w_s3_in.yx  = y_vec;
    assign w_s3_in.ok  = y_side.ok && y_ok;

    lvbm_cross #(.A_BITS(VB), .SIDE_BITS($bits(t_s3))) u_cross_yz (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(y_vld),
        .i_a(y_side.xx), .i_b(y_side.un), .i_side(w_s3_in),
        .o_valid(c3_vld), .o_c(c3_c), .o_side(c3_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_vld <= 1'b0;
            r_d2_vld <= 1'b0;
        end else if (w_en) begin
            r_d1_vld <= c3_vld;
            r_d2_vld <= r_d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [CB-1:0]      cm;
        logic [CB-1:0]      rs;
        logic [2:0][VB-1:0] bv;
        logic [MB-1:0]      mx;
        logic [W-1:0]       me;
        if (w_en) begin
            r_d1_s <= c3_side;
            for (int i = 0; i < 3; i++) begin
                cm = c3_c[i][CB-1] ? (~c3_c[i] + 1'b1) : c3_c[i];
                rs = (cm + (CB'(1) << (F - 1))) >> F;
                r_d1_yz[i] <= c3_c[i][CB-1] ? -YB'(rs) : YB'(rs);
            end
            for (int k = 0; k < 3; k++) begin
                case (k)
                    0:       bv = c3_side.xx;
                    1:       bv = c3_side.yx;
                    default: bv = c3_side.zx;
                endcase
                for (int i = 0; i < 3; i++) begin
                    mx = bv[i][VB-1] ? MB'(~bv[i] + 1'b1) : MB'(bv[i]);
                    me = c3_side.eye[i][W-1] ? (~c3_side.eye[i] + 1'b1) : c3_side.eye[i];
                    r_d1_a[k][i] <= (HB+MB)'(mx) * (HB+MB)'(HB'(me >> SP));
                    r_d1_b[k][i] <= (SP+MB)'(mx) * (SP+MB)'(me[SP-1:0]);
                    r_d1_n[k][i] <= bv[i][VB-1] != c3_side.eye[i][W-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [RW-1:0] m;
        if (w_en) begin
            r_d2_s  <= r_d1_s;
            r_d2_yz <= r_d1_yz;
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    m = (RW'(r_d1_a[k][i]) << (SP - F)) +
                        RW'((r_d1_b[k][i] + ((SP+MB)'(1) << (F - 1))) >> F);
                    r_d2_r[k][i] <= r_d1_n[k][i] ? -m : m;
                end
            end
        end
    end

    always_comb begin
        n_row = r_row + 2'd1;
        n_mat = r_mat;
        if (r_row == lvbm_pkg::ROW_LAST) begin
            n_row = lvbm_pkg::ROW_FIRST;
            case (r_mat)
                lvbm_pkg::MAT_VIEW: n_mat = lvbm_pkg::MAT_FULL;
                lvbm_pkg::MAT_FULL: n_mat = lvbm_pkg::MAT_YAXIS;
                default:            n_mat = lvbm_pkg::MAT_VIEW;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it_vld <= 1'b0;
            r_mat    <= lvbm_pkg::MAT_VIEW;
            r_row    <= lvbm_pkg::ROW_FIRST;
        end else if (w_en) begin
            r_it_vld <= r_d2_vld;
            r_mat    <= lvbm_pkg::MAT_VIEW;
            r_row    <= lvbm_pkg::ROW_FIRST;
        end else if (w_take) begin
            r_mat <= n_mat;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [DSW-1:0] s;
        if (w_en) begin
            r_it_ok <= r_d2_s.ok;
            for (int i = 0; i < 3; i++) begin
                r_xx[i] <= f_sat(SB'($signed(r_d2_s.xx[i])));
                r_yx[i] <= f_sat(SB'($signed(r_d2_s.yx[i])));
                r_zx[i] <= f_sat(SB'($signed(r_d2_s.zx[i])));
                r_un[i] <= f_sat(SB'($signed(r_d2_s.un[i])));
                r_yz[i] <= f_sat(SB'($signed(r_d2_yz[i])));
            end
            for (int k = 0; k < 3; k++) begin
                s = -(DSW'($signed(r_d2_r[k][0])) + DSW'($signed(r_d2_r[k][1])) +
                      DSW'($signed(r_d2_r[k][2])));
                r_dot[k] <= f_sat(SB'(s));
            end
        end
    end

    assign w_one = f_sat(ONE_Q);

    always_comb begin
        w_vec = '0;
        w_col = '0;
        case (r_mat)
            lvbm_pkg::MAT_VIEW: begin
                case (r_row)
                    2'd0:    w_vec = r_xx;
                    2'd1:    w_vec = r_yx;
                    default: w_vec = r_zx;
                endcase
            end
            lvbm_pkg::MAT_FULL: begin
                case (r_row)
                    2'd0:    w_vec = r_xx;
                    2'd1:    w_vec = r_yx;
                    default: w_vec = r_zx;
                endcase
            end
            default: begin
                case (r_row)
                    2'd0:    w_vec = r_xx;
                    2'd1:    w_vec = r_un;
                    default: w_vec = r_yz;
                endcase
            end
        endcase
        if (r_it_ok) begin
            if (r_row == lvbm_pkg::ROW_LAST) begin
                w_col[3] = w_one;
                if (r_mat == lvbm_pkg::MAT_VIEW) begin
                    w_col[0] = r_dot[0];
                    w_col[1] = r_dot[1];
                    w_col[2] = r_dot[2];
                end
            end else if (r_mat == lvbm_pkg::MAT_VIEW) begin
                w_col[0] = r_xx[r_row];
                w_col[1] = r_yx[r_row];
                w_col[2] = r_zx[r_row];
            end else begin
                w_col[0] = w_vec[0];
                w_col[1] = w_vec[1];
                w_col[2] = w_vec[2];
            end
        end
    end

    assign o_valid      = r_it_vld;
    assign o_matrix_id  = r_mat;
    assign o_row_index  = r_row;
    assign o_col0       = w_col[0];
    assign o_col1       = w_col[1];
    assign o_col2       = w_col[2];
    assign o_col3       = w_col[3];
    assign o_degenerate = !r_it_ok;
    assign o_last_row   = w_last;

endmodule
